// File: sv/tvdds_pkg.sv
// ----------------------------------------------------------------------------
// tvdds_pkg: shared types and constants of the two-voice DDS note player
// Register indexes, fixed field widths and the bundles passed between units.
// ----------------------------------------------------------------------------
package tvdds_pkg;

  // Fixed field widths
  localparam int unsigned PitchW = 8;
  localparam int unsigned DurW   = 8;
  localparam int unsigned IncW   = 16;
  localparam int unsigned HoldW  = 14;
  localparam int unsigned WaitW  = 16;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDurationScale = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVoiceHold     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLoopPause     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLowLimit      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHighLimit     = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0]        RstDurationScale = 8'd230;
  localparam logic [HoldW-1:0]  RstVoiceHold     = 14'd6000;
  localparam logic [WaitW-1:0]  RstLoopPause     = 16'd60000;
  localparam logic [PitchW-1:0] RstLowLimit      = 8'd80;
  localparam logic [PitchW-1:0] RstHighLimit     = 8'd96;

  // Pitch codes
  localparam logic [PitchW-1:0] EndPitch      = 8'd0;
  localparam logic [PitchW-1:0] MinTunedPitch = 8'd62;

  typedef struct packed {
    logic [7:0]        duration_scale;
    logic [HoldW-1:0]  voice_hold_ticks;
    logic [WaitW-1:0]  loop_pause_ticks;
    logic [PitchW-1:0] low_voice_limit;
    logic [PitchW-1:0] high_voice_limit;
  } cfg_t;

  // Retune request from the sequencer to one voice
  typedef struct packed {
    logic             load;
    logic [IncW-1:0]  inc;
    logic [HoldW-1:0] hold;
  } tune_t;

endpackage

// File: sv/tvdds_if.sv
// ----------------------------------------------------------------------------
// tvdds_if: valid/ready channels of the note player
// One channel carries the song entry of a tick, the other the tick's result.
// ----------------------------------------------------------------------------
interface tvdds_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  song_pitch;
  logic [7:0]  song_duration;
  logic [15:0] song_increment;

  modport source (output valid, song_pitch, song_duration, song_increment, input ready);
  modport sink   (input valid, song_pitch, song_duration, song_increment, output ready);
endinterface

interface tvdds_out_if;
  logic       valid;
  logic       ready;
  logic       voice_a_level;
  logic       voice_b_level;
  logic [9:0] next_song_index;

  modport source (output valid, voice_a_level, voice_b_level, next_song_index, input ready);
  modport sink   (input valid, voice_a_level, voice_b_level, next_song_index, output ready);
endinterface

// File: sv/tvdds_seq.sv
// ----------------------------------------------------------------------------
// tvdds_seq: song sequencer
// Wait countdown, song position and retune decisions for both voices.
// ----------------------------------------------------------------------------
module tvdds_seq
  import tvdds_pkg::*;
#(
  parameter int unsigned SONG_LENGTH = 1024,
  parameter int unsigned PosW = (SONG_LENGTH > 1) ? $clog2(SONG_LENGTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cfg_t              cfg_i,
  input  logic [PitchW-1:0] pitch_i,
  input  logic [DurW-1:0]   dur_i,
  input  logic [IncW-1:0]   inc_i,
  output tune_t             tune_a_o,
  output tune_t             tune_b_o,
  output logic [PosW-1:0]   pos_o
);

  localparam logic [PosW:0] LastPos = (PosW+1)'(SONG_LENGTH - 1);

  logic [WaitW-1:0] wait_q, wait_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             taken, tuned, to_b, to_a;
  logic [15:0]      dur_prod;

  assign taken    = (wait_q == '0);
  assign tuned    = (pitch_i >= MinTunedPitch);
  assign to_b     = tuned && (pitch_i < cfg_i.low_voice_limit);
  assign to_a     = tuned && !(pitch_i < cfg_i.low_voice_limit)
                    && (pitch_i < cfg_i.high_voice_limit);
  assign dur_prod = cfg_i.duration_scale * dur_i;

  always_comb begin
    wait_d = wait_q;
    pos_d  = pos_q;
    if (!taken) begin
      wait_d = wait_q - 1'b1;
    end else if (pitch_i == EndPitch) begin
      wait_d = cfg_i.loop_pause_ticks;
      pos_d  = '0;
    end else begin
      wait_d = dur_prod;
      // wrap after the last entry
      if ({1'b0, pos_q} >= LastPos) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  assign tune_a_o = '{load: taken && to_a, inc: inc_i, hold: cfg_i.voice_hold_ticks};
  assign tune_b_o = '{load: taken && to_b, inc: inc_i, hold: cfg_i.voice_hold_ticks};
  assign pos_o    = pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= '0;
      pos_q  <= '0;
    end else if (step_i) begin
      wait_q <= wait_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// File: sv/tvdds_voice.sv
// ----------------------------------------------------------------------------
// tvdds_voice: one DDS square-wave voice
// Phase accumulator with a hold countdown; level compares phase to 4x hold.
// ----------------------------------------------------------------------------
module tvdds_voice
  import tvdds_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 17
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  tune_t tune_i,
  output logic  level_o
);

  localparam int unsigned CmpW = (PHASE_BITS > HoldW + 2) ? PHASE_BITS : HoldW + 2;

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [IncW-1:0]       inc_q, inc_cur;
  logic [HoldW-1:0]      hold_q, hold_cur, hold_d;
  logic                  active;

  // a retune in this tick already takes effect
  assign inc_cur  = tune_i.load ? tune_i.inc : inc_q;
  assign hold_cur = tune_i.load ? tune_i.hold : hold_q;
  assign active   = (hold_cur != '0);

  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_cur;
    level_o = 1'b0;
    if (active) begin
      phase_d = phase_q + PHASE_BITS'(inc_cur);
      level_o = (CmpW'(phase_d) > CmpW'({hold_cur, 2'b00}));
      hold_d  = hold_cur - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      inc_q   <= '0;
      hold_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      inc_q   <= inc_cur;
      hold_q  <= hold_d;
    end
  end

endmodule

// File: sv/two_voice_dds_note_player_core.sv
// ----------------------------------------------------------------------------
// two_voice_dds_note_player_core: two-voice DDS square-wave note player
// Plays a song one audio tick per beat, retuning two square-wave voices.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                          | beat
//  --------+-----+--------------------------------------------------+----------------
//  in_s    | in  | song_pitch, song_duration, song_increment        | one audio tick
//  out_s   | out | voice_a_level, voice_b_level, next_song_index    | one tick result
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i                 | one register write
//
//  An input beat is held in the input register, then passes through the
//  sequencer and voice logic into the result register. One beat per cycle
//  is sustained in both directions while the output does not stall.
//  A stalled output holds the result register; the input register keeps
//  taking beats until it is also occupied, then ready drops.
//  Reset clears the song state, both voices and the config registers to their
//  defaults; no clearing pass is needed.
//
module two_voice_dds_note_player_core
  import tvdds_pkg::*;
#(
  parameter int unsigned SONG_LENGTH = 1024,
  parameter int unsigned PHASE_BITS  = 17
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tvdds_in_if.sink            in_s,
  tvdds_out_if.source         out_s,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned PosW = (SONG_LENGTH > 1) ? $clog2(SONG_LENGTH) : 1;
  localparam int unsigned ExtW = (PosW > IndexW) ? PosW : IndexW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duration_scale   <= RstDurationScale;
      cfg_q.voice_hold_ticks <= RstVoiceHold;
      cfg_q.loop_pause_ticks <= RstLoopPause;
      cfg_q.low_voice_limit  <= RstLowLimit;
      cfg_q.high_voice_limit <= RstHighLimit;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDurationScale: cfg_q.duration_scale   <= cfg_wdata_i[7:0];
        RegVoiceHold:     cfg_q.voice_hold_ticks <= cfg_wdata_i[HoldW-1:0];
        RegLoopPause:     cfg_q.loop_pause_ticks <= cfg_wdata_i[WaitW-1:0];
        RegLowLimit:      cfg_q.low_voice_limit  <= cfg_wdata_i[PitchW-1:0];
        RegHighLimit:     cfg_q.high_voice_limit <= cfg_wdata_i[PitchW-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic              in_valid_q;
  logic [PitchW-1:0] pitch_q;
  logic [DurW-1:0]   dur_q;
  logic [IncW-1:0]   inc_q;
  logic              res_valid_q;
  logic              advance, fire, in_take;

  // the result register can take a new tick when empty or being drained
  assign advance   = !res_valid_q || out_s.ready;
  assign fire      = in_valid_q && advance;
  assign in_s.ready = !in_valid_q || advance;
  assign in_take   = in_s.valid && in_s.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pitch_q <= in_s.song_pitch;
      dur_q   <= in_s.song_duration;
      inc_q   <= in_s.song_increment;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick logic: sequencer and two voices, committed on fire
  // ---------------------------------------------------------------------------
  tune_t           tune_a, tune_b;
  logic [PosW-1:0] pos_next;
  logic            level_a, level_b;
  logic [ExtW-1:0] pos_ext;

  tvdds_seq #(
    .SONG_LENGTH (SONG_LENGTH),
    .PosW        (PosW)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .cfg_i    (cfg_q),
    .pitch_i  (pitch_q),
    .dur_i    (dur_q),
    .inc_i    (inc_q),
    .tune_a_o (tune_a),
    .tune_b_o (tune_b),
    .pos_o    (pos_next)
  );

  tvdds_voice #(.PHASE_BITS (PHASE_BITS)) u_voice_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (fire),
    .tune_i  (tune_a),
    .level_o (level_a)
  );

  tvdds_voice #(.PHASE_BITS (PHASE_BITS)) u_voice_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (fire),
    .tune_i  (tune_b),
    .level_o (level_b)
  );

  // report the low index bits, zero-extended for short songs
  assign pos_ext = ExtW'(pos_next);

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic              level_a_q, level_b_q;
  logic [IndexW-1:0] index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (out_s.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      level_a_q <= level_a;
      level_b_q <= level_b;
      index_q   <= pos_ext[IndexW-1:0];
    end
  end

  assign out_s.valid           = res_valid_q;
  assign out_s.voice_a_level   = level_a_q;
  assign out_s.voice_b_level   = level_b_q;
  assign out_s.next_song_index = index_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // song position never leaves the song
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pos_next) <= SONG_LENGTH - 1))
    else $error("song position beyond song length");

  // a full input register facing a stalled result must not take a beat
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && res_valid_q && !out_s.ready) |-> !in_s.ready)
    else $error("input register overrun under stall");

  // every committed tick shows up as a result
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_valid_q)
    else $error("committed tick lost");

  // the two voices are never retuned by the same entry
  a_one_retune: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> !(tune_a.load && tune_b.load))
    else $error("both voices retuned in one tick");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-voice DDS note player
// Drives song ticks over the input channel, predicts every tick result from a
// cycle-free model of the sequencer and both voices, and compares each result
// beat field by field. Runs directed cases and then random songs under
// several register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import tvdds_pkg::*;

  localparam int unsigned SongLength = 1024;
  localparam int unsigned PhaseBits  = 17;

  typedef struct packed {
    logic [PitchW-1:0] pitch;
    logic [DurW-1:0]   dur;
    logic [IncW-1:0]   inc;
  } song_entry_t;

  typedef struct packed {
    logic              level_a;
    logic              level_b;
    logic [IndexW-1:0] index;
  } tick_result_t;

  typedef enum int { VoiceA = 0, VoiceB = 1 } voice_e;
  typedef enum int { SideTx = 0, SideRx = 1 } side_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  tvdds_in_if  in_ch ();
  tvdds_out_if out_ch ();

  two_voice_dds_note_player_core #(
    .SONG_LENGTH (SongLength),
    .PHASE_BITS  (PhaseBits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_ch),
    .out_s       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Player model: register shadow, song sequencer and both voices
  // --------------------------------------------------------------------------
  cfg_t regs = '{RstDurationScale, RstVoiceHold, RstLoopPause, RstLowLimit, RstHighLimit};

  logic [WaitW-1:0]     wait_left   = '0;
  int unsigned          song_pos    = 0;
  logic [PhaseBits-1:0] vphase [2]  = '{default: '0};
  logic [IncW-1:0]      vinc   [2]  = '{default: '0};
  logic [HoldW-1:0]     vhold  [2]  = '{default: '0};
  int unsigned          entries_taken = 0;

  tick_result_t expected_ticks [$];
  int unsigned  failures = 0;

  // Song contents the stimulus follows, indexed by the predicted position
  song_entry_t song_rom [SongLength];

  // Idle control shared by the sender and the receiver
  logic no_idle = 1'b0;
  int   calm_left [2] = '{default: 0};

  // Advance one voice by a tick; an idle voice (hold at zero) stays low.
  function automatic logic voice_tick(voice_e v);
    logic lvl;
    lvl = 1'b0;
    if (vhold[v] != '0) begin
      vphase[v] = vphase[v] + PhaseBits'(vinc[v]);
      lvl       = (vphase[v] > {vhold[v], 2'b00});
      vhold[v]  = vhold[v] - 1'b1;
    end
    return lvl;
  endfunction

  // One audio tick: take the entry only once the wait has run out.
  function automatic tick_result_t play_tick(song_entry_t e);
    tick_result_t r;
    if (wait_left != '0) begin
      wait_left = wait_left - 1'b1;
    end else begin
      entries_taken++;
      // Low limit is tested first, so voice B wins when the limits cross
      if (e.pitch >= MinTunedPitch) begin
        if (e.pitch < regs.low_voice_limit) begin
          vinc[VoiceB]  = e.inc;
          vhold[VoiceB] = regs.voice_hold_ticks;
        end else if (e.pitch < regs.high_voice_limit) begin
          vinc[VoiceA]  = e.inc;
          vhold[VoiceA] = regs.voice_hold_ticks;
        end
      end
      if (e.pitch == EndPitch) begin
        song_pos  = 0;
        wait_left = regs.loop_pause_ticks;
      end else begin
        wait_left = {8'd0, regs.duration_scale} * {8'd0, e.dur};
        song_pos  = (song_pos == SongLength - 1) ? 0 : song_pos + 1;
      end
    end
    // A voice retuned in this tick already sounds with its new values
    r.level_a = voice_tick(VoiceA);
    r.level_b = voice_tick(VoiceB);
    r.index   = IndexW'(song_pos);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random picks
  // --------------------------------------------------------------------------
  // Mostly no gap, some short ones, a few long ones, and now and then a calm
  // stretch with no idling at all.
  function automatic int idle_len(side_e side);
    int r;
    if (no_idle) return 0;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keep the wait an entry causes short enough for the run length.
  function automatic logic [DurW-1:0] pick_duration();
    logic [DurW-1:0] d;
    if (regs.duration_scale == '0 || $urandom_range(0, 99) >= 75) begin
      d = DurW'($urandom_range(0, 255));
    end else begin
      d = DurW'($urandom_range(0, 3));
    end
    if ({8'd0, regs.duration_scale} * {8'd0, d} > 24) d = d % 4;
    return d;
  endfunction

  function automatic logic [IncW-1:0] pick_increment();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return IncW'($urandom_range(0, 65535));
  endfunction

  // Favor tuned pitches and the edges around both limits.
  function automatic logic [PitchW-1:0] pick_pitch(logic allow_end);
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 5 && allow_end) return EndPitch;
    if (r < 12) return PitchW'($urandom_range(1, int'(MinTunedPitch) - 1));
    if (r < 32) begin
      p = (r < 22) ? int'(regs.low_voice_limit) : int'(regs.high_voice_limit);
      p = p + $urandom_range(0, 2) - 1;
      if (p < 1) p = 1;
      if (p > 255) p = 255;
      return PitchW'(p);
    end
    return PitchW'($urandom_range(int'(MinTunedPitch), 255));
  endfunction

  function automatic song_entry_t noise_entry(logic allow_end);
    song_entry_t e;
    e.pitch = PitchW'($urandom_range(allow_end ? 0 : 1, 255));
    e.dur   = pick_duration();
    e.inc   = pick_increment();
    return e;
  endfunction

  // Mostly the entry at the predicted position, sometimes garbage.
  function automatic song_entry_t next_entry(int noise_pct, logic allow_end);
    if ($urandom_range(0, 99) < noise_pct) return noise_entry(allow_end);
    return song_rom[song_pos];
  endfunction

  function automatic void fill_song(logic allow_end);
    for (int i = 0; i < SongLength; i++) begin
      song_rom[i] = '{pick_pitch(allow_end), pick_duration(), pick_increment()};
    end
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 30)      s.duration_scale = '0;
    else if (r < 80) s.duration_scale = 8'($urandom_range(1, 2));
    else             s.duration_scale = 8'($urandom_range(3, 255));
    r = $urandom_range(0, 99);
    if (r < 8)       s.voice_hold_ticks = '0;
    else if (r < 40) s.voice_hold_ticks = HoldW'($urandom_range(1, 64));
    else if (r < 80) s.voice_hold_ticks = HoldW'($urandom_range(65, 4000));
    else             s.voice_hold_ticks = HoldW'($urandom_range(4001, 16383));
    s.loop_pause_ticks = WaitW'($urandom_range(0, 40));
    s.low_voice_limit  = ($urandom_range(0, 9) == 0) ? PitchW'($urandom_range(0, 1) * 255)
                                                     : PitchW'($urandom_range(50, 140));
    s.high_voice_limit = ($urandom_range(0, 9) == 0) ? PitchW'($urandom_range(0, 1) * 255)
                                                     : PitchW'($urandom_range(60, 200));
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Channel and register drivers
  // --------------------------------------------------------------------------
  // Send one tick beat; predict its result on the edge it is accepted.
  task automatic send_entry(song_entry_t e);
    int gap;
    gap = idle_len(SideTx);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.song_pitch     <= e.pitch;
    in_ch.song_duration  <= e.dur;
    in_ch.song_increment <= e.inc;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    expected_ticks.push_back(play_tick(e));
  endtask

  // Hold the input side until every predicted result has been seen.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Program all registers on an idle block. Bits above each register's width
  // carry garbage, and a write to an unused index must change nothing.
  task automatic apply_settings(cfg_t s);
    drain_results();
    write_reg(RegDurationScale, {8'($urandom), s.duration_scale});
    write_reg(RegVoiceHold,     {2'($urandom), s.voice_hold_ticks});
    write_reg(RegLoopPause,     s.loop_pause_ticks);
    write_reg(RegLowLimit,      {8'($urandom), s.low_voice_limit});
    write_reg(RegHighLimit,     {8'($urandom), s.high_voice_limit});
    write_reg(CfgIdxW'($urandom_range(int'(RegHighLimit) + 1, (1 << CfgIdxW) - 1)),
              CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    regs = s;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report(string field, int want, int got);
    failures++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  tick_result_t want_tick;

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_ticks.size() == 0) begin
        failures++;
        $display("%0t: result beat with no tick pending, expected none, actual %0d/%0d/%0d",
                 $time, out_ch.voice_a_level, out_ch.voice_b_level, out_ch.next_song_index);
      end else begin
        want_tick = expected_ticks.pop_front();
        if (out_ch.voice_a_level !== want_tick.level_a)
          report("voice_a_level", want_tick.level_a, out_ch.voice_a_level);
        if (out_ch.voice_b_level !== want_tick.level_b)
          report("voice_b_level", want_tick.level_b, out_ch.voice_b_level);
        if (out_ch.next_song_index !== want_tick.index)
          report("next_song_index", want_tick.index, out_ch.next_song_index);
      end
    end
  end

  // Receiver: stall the result channel at random.
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      n = idle_len(SideRx);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset values of the registers: routing at the default limits, zero waits.
  task automatic test_default_registers();
    send_entry('{8'd70, 8'd0, 16'hFFFF});                  // voice B
    send_entry('{8'd85, 8'd0, 16'h1234});                  // voice A
    send_entry('{RstHighLimit, 8'd0, 16'h8001});           // above both limits
    send_entry('{MinTunedPitch - 8'd1, 8'd0, 16'h7FFF});   // low pitch, no retune
    send_entry('{MinTunedPitch, 8'd0, 16'h0F0F});          // lowest tuned pitch
  endtask

  // Limit boundaries, end marker, extremes of duration and increment.
  task automatic test_voice_routing();
    apply_settings('{8'd0, 14'h3FFF, 16'd0, RstLowLimit, RstHighLimit});
    send_entry('{EndPitch, 8'hFF, 16'hFFFF});              // restart, zero pause
    send_entry('{regs.low_voice_limit - 8'd1, 8'hFF, 16'hFFFF});
    send_entry('{regs.high_voice_limit - 8'd1, 8'd0, 16'h0001});
    send_entry('{regs.low_voice_limit, 8'h55, 16'hAAAA});
    send_entry('{regs.high_voice_limit, 8'hAA, 16'h5555});
    send_entry('{8'd1, 8'd0, 16'h0000});
    send_entry('{8'hFF, 8'hFF, 16'hC000});
    send_entry('{MinTunedPitch, 8'd0, 16'h4000});
  endtask

  // Crossed limits, a zero hold, and limits at their extremes.
  task automatic test_odd_limits();
    apply_settings('{8'd0, 14'd0, 16'd5, 8'd200, 8'd100});
    send_entry('{8'd150, 8'd0, 16'hF00D});                 // voice B wins, stays idle
    send_entry('{8'd220, 8'd0, 16'h0BAD});                 // above both
    send_entry('{8'd90, 8'd0, 16'h1111});                  // voice B, still idle
    apply_settings('{8'd0, 14'd1, 16'd5, 8'd0, 8'd255});
    send_entry('{MinTunedPitch, 8'd0, 16'hFFFF});          // voice A, one tick
    send_entry('{8'd254, 8'd0, 16'h0003});
    send_entry('{8'd255, 8'd0, 16'hFFFF});                 // not below 255
  endtask

  // A loop pause run out with every ignored tick back to back.
  task automatic test_long_loop_pause();
    apply_settings('{8'd0, 14'd300, 16'd40, RstLowLimit, RstHighLimit});
    no_idle = 1'b1;
    send_entry('{EndPitch, 8'd7, 16'h2222});
    while (wait_left != '0) send_entry(noise_entry(1'b1));
    send_entry('{8'd70, 8'd3, 16'h3333});
    no_idle = 1'b0;
  endtask

  // More entries than the song holds, no end marker: the position must wrap.
  task automatic test_song_wrap();
    cfg_t        s;
    int unsigned start;
    s = random_settings();
    s.duration_scale = '0;
    apply_settings(s);
    fill_song(1'b0);
    start = entries_taken;
    while (entries_taken - start < SongLength + 8) send_entry(next_entry(10, 1'b0));
  endtask

  // Random songs under random settings, the last one with the largest scale.
  task automatic test_random_songs();
    cfg_t s;
    for (int ph = 0; ph < 4; ph++) begin
      s = random_settings();
      if (ph == 3) s.duration_scale = '1;
      apply_settings(s);
      fill_song(1'b1);
      for (int n = 0; n < 16; n++) begin
        if ($urandom_range(0, 99) < 2) drain_results();
        send_entry(next_entry(15, 1'b1));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset, sequence and end of run
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= RegDurationScale;
    cfg_wdata_i          <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.song_pitch     <= EndPitch;
    in_ch.song_duration  <= '0;
    in_ch.song_increment <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_registers();
    test_voice_routing();
    test_odd_limits();
    test_long_loop_pause();
    test_song_wrap();
    test_random_songs();

    // Let the last results out, then watch for stray beats
    drain_results();
    repeat (10) @(posedge clk_i);
    if (failures == 0 && expected_ticks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
